@@ design/krt_pkg.sv @@
package krt_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_UPDATE = 2'd3
    } t_op;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_FULL     = 2'd1;
    localparam t_status STAT_NOTFOUND = 2'd2;

    localparam int KEY_W = 32;
    localparam int AGE_W = 8;

    typedef struct packed {
        logic exec;
        t_op  op;
    } t_cell_ctl;

endpackage

@@ design/krt_cell.sv @@
module krt_cell
    import krt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int NW  = 64
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CW-1:0]    i_count,
    input  logic [NW-1:0]    i_wr_name,
    input  logic [AGE_W-1:0] i_wr_age,
    input  logic             i_prev_hit,
    input  logic [NW-1:0]    i_prev_name,
    input  logic [AGE_W-1:0] i_prev_age,
    input  logic [KEY_W-1:0] i_next_key,
    input  logic [NW-1:0]    i_next_name,
    input  logic [AGE_W-1:0] i_next_age,
    output logic             o_hit,
    output logic [NW-1:0]    o_fwd_name,
    output logic [AGE_W-1:0] o_fwd_age,
    output logic [KEY_W-1:0] o_key,
    output logic [NW-1:0]    o_name,
    output logic [AGE_W-1:0] o_age
);

    logic [KEY_W-1:0] r_key;
    logic [NW-1:0]    r_name;
    logic [AGE_W-1:0] r_age;

    logic live;
    logic self_hit;
    logic first;

    assign live     = i_count > CW'(IDX);
    assign self_hit = live && (r_key == i_key);
    assign first    = self_hit && !i_prev_hit;
    assign o_hit    = i_prev_hit | self_hit;

    assign o_fwd_name = first ? r_name : i_prev_name;
    assign o_fwd_age  = first ? r_age  : i_prev_age;

    assign o_key  = r_key;
    assign o_name = r_name;
    assign o_age  = r_age;

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            unique case (i_ctl.op)
                OP_ADD: begin
                    if (i_count == CW'(IDX)) begin
                        r_key  <= i_key;
                        r_name <= i_wr_name;
                        r_age  <= i_wr_age;
                    end
                end
                OP_UPDATE: begin
                    if (first) begin
                        r_name <= i_wr_name;
                        r_age  <= i_wr_age;
                    end
                end
                OP_DELETE: begin
                    // the matched slot and every later one take the next record
                    if (o_hit) begin
                        r_key  <= i_next_key;
                        r_name <= i_next_name;
                        r_age  <= i_next_age;
                    end
                end
                OP_FIND: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/keyed_record_table.sv @@
// Keyed record table: up to TABLE_DEPTH records (32-bit key, NAME_BYTES-byte
// name, 8-bit age) kept densely in insertion order in a row of cells. Add
// appends or reports full; find, delete and update act on the first record
// whose key matches, and delete moves every later record down one cell in the
// same cycle. A request is registered in ST_IDLE; in ST_EXEC, once no held
// result is stalled, all cells compare the key in parallel, the first match is
// resolved along the cell chain and the table is updated. The result sits in
// an output register, so the next request is taken while it waits. Only the
// low NAME_BYTES bytes of a name are stored; update keeps at most
// NAME_BYTES-1 bytes, up to the first zero byte.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int NAME_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_key,
    input  logic [63:0] i_name_in,
    input  logic [7:0]  i_age_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_found_name,
    output logic [7:0]  o_found_age,
    output logic [4:0]  o_entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = NAME_BYTES * 8;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [63:0]      r_name;
    logic [AGE_W-1:0] r_age;
    logic [CW-1:0]    r_count;
    logic             r_out_valid;
    t_status          r_status;
    logic [NW-1:0]    r_fname;
    logic [AGE_W-1:0] r_fage;

    logic             accept;
    logic             exec;
    logic             any_hit;
    logic             full;
    logic             stop;
    logic [NW-1:0]    name_trunc;
    logic [NW-1:0]    wr_name;
    t_status          n_status;
    logic [CW-1:0]    n_count;
    t_cell_ctl        cell_ctl;

    logic             hit_chain  [0:TABLE_DEPTH];
    logic [NW-1:0]    name_chain [0:TABLE_DEPTH];
    logic [AGE_W-1:0] age_chain  [0:TABLE_DEPTH];
    logic [KEY_W-1:0] c_key      [0:TABLE_DEPTH-1];
    logic [NW-1:0]    c_name     [0:TABLE_DEPTH-1];
    logic [AGE_W-1:0] c_age      [0:TABLE_DEPTH-1];

    assign o_stall = (r_state == ST_EXEC);
    assign accept  = i_valid && !o_stall;
    assign exec    = (r_state == ST_EXEC) && (!r_out_valid || !i_stall);
    assign full    = (r_count == CW'(TABLE_DEPTH));
    assign any_hit = hit_chain[TABLE_DEPTH];

    assign cell_ctl.exec = exec;
    assign cell_ctl.op   = r_op;

    always_comb begin
        name_trunc = '0;
        stop       = 1'b0;
        for (int b = 0; b < NAME_BYTES - 1; b++) begin
            if (r_name[8*b +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                name_trunc[8*b +: 8] = r_name[8*b +: 8];
            end
        end
    end

    assign wr_name = (r_op == OP_UPDATE) ? name_trunc : r_name[NW-1:0];

    always_comb begin
        n_count = r_count;
        if (r_op == OP_ADD) begin
            n_status = full ? STAT_FULL : STAT_OK;
            if (!full) begin
                n_count = r_count + CW'(1);
            end
        end else begin
            n_status = any_hit ? STAT_OK : STAT_NOTFOUND;
            if (any_hit && r_op == OP_DELETE) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    assign hit_chain[0]  = 1'b0;
    assign name_chain[0] = '0;
    assign age_chain[0]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] next_key;
        logic [NW-1:0]    next_name;
        logic [AGE_W-1:0] next_age;

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign next_key  = c_key[i];
            assign next_name = c_name[i];
            assign next_age  = c_age[i];
        end else begin : g_mid
            assign next_key  = c_key[i+1];
            assign next_name = c_name[i+1];
            assign next_age  = c_age[i+1];
        end

        krt_cell #(
            .IDX (i),
            .CW  (CW),
            .NW  (NW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_key       (r_key),
            .i_count     (r_count),
            .i_wr_name   (wr_name),
            .i_wr_age    (r_age),
            .i_prev_hit  (hit_chain[i]),
            .i_prev_name (name_chain[i]),
            .i_prev_age  (age_chain[i]),
            .i_next_key  (next_key),
            .i_next_name (next_name),
            .i_next_age  (next_age),
            .o_hit       (hit_chain[i+1]),
            .o_fwd_name  (name_chain[i+1]),
            .o_fwd_age   (age_chain[i+1]),
            .o_key       (c_key[i]),
            .o_name      (c_name[i]),
            .o_age       (c_age[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !exec) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                        r_op    <= t_op'(i_operation);
                        r_key   <= i_key;
                        r_name  <= i_name_in;
                        r_age   <= i_age_in;
                    end
                end
                ST_EXEC: begin
                    if (exec) begin
                        r_state     <= ST_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_status    <= n_status;
                        if (r_op == OP_FIND && any_hit) begin
                            r_fname <= name_chain[TABLE_DEPTH];
                            r_fage  <= age_chain[TABLE_DEPTH];
                        end else begin
                            r_fname <= '0;
                            r_fage  <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_name  = 64'(r_fname);
    assign o_found_age   = r_fage;
    assign o_entry_count = 5'(r_count);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_op == OP_ADD && !full |=> r_count == $past(r_count) + CW'(1))
        else $error("add did not grow the table");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == STAT_FULL |-> full)
        else $error("full status while table not full");

    a_no_data_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != STAT_OK |-> r_fname == '0 && r_fage == '0)
        else $error("record data returned on failed transaction");

endmodule
